// ----- rtl/core/mfps_pkg.sv -----
package mfps_pkg;

   localparam int VALUE_W = 16;
   localparam int SUM_W   = 32;
   localparam int COLS_W  = 9;

   localparam logic [COLS_W-1:0] COLS_RESET = 9'd256;

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic signed [SUM_W-1:0]   sum_type;
   typedef logic [COLS_W-1:0]         cols_type;

   localparam sum_type SUM_MAX = 32'sh7FFF_FFFF;
   localparam sum_type SUM_MIN = 32'sh8000_0000;

endpackage

// ----- rtl/core/mfps_req_if.sv -----
interface mfps_req_if import mfps_pkg::*; ();

   logic      valid;
   logic      ready;
   value_type value;
   logic      last;

   modport source (output valid, output value, output last, input ready);
   modport sink   (input valid, input value, input last, output ready);

endinterface

// ----- rtl/core/mfps_rsp_if.sv -----
interface mfps_rsp_if import mfps_pkg::*; ();

   logic    valid;
   logic    ready;
   sum_type min_sum;

   modport source (output valid, output min_sum, input ready);
   modport sink   (input valid, input min_sum, output ready);

endinterface

// ----- rtl/core/min_falling_path_sum_core.sv -----
// Throughput: one item per cycle while the result queue has room; req_bus.ready drops when it is full.
// The result of an item flagged last is registered in stage 1, then written into the result queue for rsp_bus.
// A four-entry result queue keeps the input flowing while results wait on rsp_bus.ready.
// Reset (synchronous, active high) clears indices, flags, running minimum, queue and columns
// (to 256). The row store is not cleared; it needs no clearing pass.
module min_falling_path_sum_core import mfps_pkg::*; #(
   parameter int MAX_COLUMNS = 256
) (
   input  logic          clock,
   input  logic          reset,
   mfps_req_if.sink      req_bus,
   mfps_rsp_if.source    rsp_bus,
   input  logic          csr_write_enable,
   input  cols_type      csr_write_data
);

   localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int CW = AW + 1;
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_COLUMNS);
   localparam int OUT_DEPTH = 4;

   // ------------------------------------------------------------------
   // Row width register
   // ------------------------------------------------------------------
   cols_type cols_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= COLS_RESET;
      end else if (csr_write_enable) begin
         cols_ff <= csr_write_data;
      end
   end

   // Clamp to 1..MAX_COLUMNS
   logic [CW-1:0] cols_eff;

   always_comb begin
      if (cols_ff == '0) begin
         cols_eff = CW'(1);
      end else if (32'(cols_ff) > 32'(MAX_COLUMNS)) begin
         cols_eff = MAX_CNT;
      end else begin
         cols_eff = CW'(cols_ff);
      end
   end

   // ------------------------------------------------------------------
   // Accept stage: column tracking and row store read issue
   // ------------------------------------------------------------------
   logic [AW-1:0] col_ff;
   logic          first_row_ff;
   logic [CW-1:0] col_next;
   logic          has_right;
   logic [AW-1:0] right_addr;
   logic          accept;
   logic [2:0]    out_count_ff;
   logic          s1_valid_ff;
   logic          s1_last_ff;
   logic          push;

   assign accept     = req_bus.valid && req_bus.ready;
   assign col_next   = {1'b0, col_ff} + CW'(1);
   assign has_right  = col_next < cols_eff;
   assign right_addr = col_ff + AW'(1);
   assign push       = s1_valid_ff && s1_last_ff;

   // Reserve a queue slot for an item flagged last still in flight.
   assign req_bus.ready = (out_count_ff + 3'(push)) < 3'(OUT_DEPTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         first_row_ff <= 1'b1;
      end else if (accept) begin
         if (req_bus.last) begin
            col_ff       <= '0;
            first_row_ff <= 1'b1;
         end else if (!has_right) begin
            col_ff       <= '0;
            first_row_ff <= 1'b0;
         end else begin
            col_ff <= col_next[AW-1:0];
         end
      end
   end

   // Row store: one write port (stage 1), two read ports (accept)
   sum_type row_mem [MAX_COLUMNS];
   sum_type rd_up_ff;
   sum_type rd_right_ff;

   // Stage 1 payload
   value_type     s1_value_ff;
   logic          s1_first_ff;
   logic [AW-1:0] s1_col_ff;
   logic          s1_left_ok_ff;
   logic          s1_right_ok_ff;
   logic          s1_end_row_ff;
   sum_type       s1_sum;

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_up_ff    <= row_mem[col_ff];
         rd_right_ff <= row_mem[right_addr];
      end
      if (s1_valid_ff) begin
         row_mem[s1_col_ff] <= s1_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_value_ff    <= req_bus.value;
         s1_last_ff     <= req_bus.last;
         s1_first_ff    <= first_row_ff;
         s1_col_ff      <= col_ff;
         s1_left_ok_ff  <= col_ff != '0;
         s1_right_ok_ff <= has_right;
         s1_end_row_ff  <= !has_right;
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: neighbor select, add, saturate, write back
   // ------------------------------------------------------------------
   // The item ahead writes the store at the same edge our reads issue,
   // so its sum is forwarded when the address matches (narrow rows).
   logic          fwd_valid_ff;
   logic [AW-1:0] fwd_addr_ff;
   sum_type       fwd_sum_ff;
   sum_type       held_left_ff;
   sum_type       row_min_ff;
   logic [AW-1:0] s1_right_addr;
   sum_type       up_eff;
   sum_type       right_eff;
   sum_type       best;
   logic signed [SUM_W:0] wide;
   sum_type       sat_sum;
   sum_type       min_new;

   assign s1_right_addr = s1_col_ff + AW'(1);
   assign up_eff    = (fwd_valid_ff && fwd_addr_ff == s1_col_ff) ? fwd_sum_ff : rd_up_ff;
   assign right_eff = (fwd_valid_ff && fwd_addr_ff == s1_right_addr) ? fwd_sum_ff
                                                                     : rd_right_ff;

   always_comb begin
      best = up_eff;
      if (s1_left_ok_ff && (held_left_ff < best)) begin
         best = held_left_ff;
      end
      if (s1_right_ok_ff && (right_eff < best)) begin
         best = right_eff;
      end
   end

   assign wide = $signed({{(SUM_W + 1 - VALUE_W){s1_value_ff[VALUE_W-1]}}, s1_value_ff})
               + $signed({best[SUM_W-1], best});

   always_comb begin
      if (wide[SUM_W] != wide[SUM_W-1]) begin
         sat_sum = wide[SUM_W] ? SUM_MIN : SUM_MAX;
      end else begin
         sat_sum = wide[SUM_W-1:0];
      end
   end

   // First row: sum is the element itself
   assign s1_sum  = s1_first_ff
                  ? $signed({{(SUM_W - VALUE_W){s1_value_ff[VALUE_W-1]}}, s1_value_ff})
                  : sat_sum;
   assign min_new = (s1_sum < row_min_ff) ? s1_sum : row_min_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         held_left_ff <= '0;
         row_min_ff   <= SUM_MAX;
      end else begin
         s1_valid_ff  <= accept;
         fwd_valid_ff <= s1_valid_ff;
         if (s1_valid_ff) begin
            held_left_ff <= s1_last_ff ? sum_type'(0) : up_eff;
            row_min_ff   <= (s1_last_ff || s1_end_row_ff) ? SUM_MAX : min_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      fwd_addr_ff <= s1_col_ff;
      fwd_sum_ff  <= s1_sum;
   end

   // ------------------------------------------------------------------
   // Result queue
   // ------------------------------------------------------------------
   sum_type    out_mem [OUT_DEPTH];
   logic [1:0] wr_ptr_ff;
   logic [1:0] rd_ptr_ff;
   logic       pop;

   assign rsp_bus.valid   = out_count_ff != '0;
   assign rsp_bus.min_sum = out_mem[rd_ptr_ff];
   assign pop             = rsp_bus.valid && rsp_bus.ready;

   always_ff @(posedge clock) begin
      if (push) begin
         out_mem[wr_ptr_ff] <= min_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         out_count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 2'd1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 2'd1;
         end
         out_count_ff <= out_count_ff + 3'(push) - 3'(pop);
      end
   end

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      out_count_ff <= 3'(OUT_DEPTH))
      else $error("result queue overfilled");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> out_count_ff < 3'(OUT_DEPTH))
      else $error("result pushed into full queue");

   a_last_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && req_bus.last) |=> (col_ff == '0 && first_row_ff))
      else $error("matrix did not restart after last item");

   a_stage_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted item missing from stage 1");

endmodule
